>>> rtl/u8mpc_pkg.sv
package u8mpc_pkg;

	localparam int LANES        = 8;
	localparam int BYTE_W       = 8;
	localparam int MAX_CHANNELS = 256;
	localparam int MAX_WINDOW   = 256;
	localparam int GROUP_DEPTH  = (MAX_CHANNELS + LANES - 1) / LANES;
	localparam int LANE_IDX_W   = $clog2(LANES);
	localparam int GRP_W        = 5;
	localparam int GRP_CNT_W    = GRP_W + 1;
	localparam int WIN_W        = $clog2(MAX_WINDOW);
	localparam int CFG_W        = 9;
	localparam int IDX_W        = 8;
	localparam int DATA_W       = LANES * BYTE_W;
	localparam int CHAN_W       = GRP_W + LANE_IDX_W;

	localparam logic [IDX_W-1:0] REG_WINDOW_SIZE   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CLAMP_LOW     = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_CLAMP_HIGH    = IDX_W'(3);

	localparam logic [CFG_W-1:0]  RST_WINDOW_SIZE   = CFG_W'(9);
	localparam logic [CFG_W-1:0]  RST_CHANNEL_COUNT = CFG_W'(16);
	localparam logic [BYTE_W-1:0] RST_CLAMP_LOW     = BYTE_W'(0);
	localparam logic [BYTE_W-1:0] RST_CLAMP_HIGH    = BYTE_W'(255);

	typedef struct packed {
		logic [GRP_W-1:0]  group;
		logic              first;
		logic              emit;
		logic              last_group;
		logic [CFG_W-1:0]  chan_count;
		logic [BYTE_W-1:0] clamp_low;
		logic [BYTE_W-1:0] clamp_high;
	} ctl_t;

	typedef struct packed {
		logic [DATA_W-1:0] pooled;
		logic [GRP_W-1:0]  group;
		logic              last_group;
	} result_t;

endpackage

>>> rtl/u8mpc_lane.sv
module u8mpc_lane (
	input  logic [u8mpc_pkg::LANE_IDX_W-1:0] lane_id,
	input  u8mpc_pkg::ctl_t                  ctl,
	input  logic [u8mpc_pkg::BYTE_W-1:0]     old_byte,
	input  logic [u8mpc_pkg::BYTE_W-1:0]     new_byte,
	output logic [u8mpc_pkg::BYTE_W-1:0]     max_byte,
	output logic [u8mpc_pkg::BYTE_W-1:0]     pooled_byte
);
	import u8mpc_pkg::*;

	logic [BYTE_W-1:0] hi_clamped;
	logic [BYTE_W-1:0] clamped;
	logic [CHAN_W-1:0] chan;
	logic              active;

	always_comb begin
		if (ctl.first) begin
			max_byte = new_byte;
		end else begin
			max_byte = (old_byte > new_byte) ? old_byte : new_byte;
		end
		hi_clamped  = (max_byte > ctl.clamp_high) ? ctl.clamp_high : max_byte;
		clamped     = (hi_clamped < ctl.clamp_low) ? ctl.clamp_low : hi_clamped;
		chan        = {ctl.group, lane_id};
		active      = {1'b0, chan} < ctl.chan_count;
		pooled_byte = active ? clamped : '0;
	end

endmodule

>>> rtl/u8mpc_ctrl.sv
module u8mpc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [u8mpc_pkg::IDX_W-1:0] cfg_index,
	input  logic [u8mpc_pkg::CFG_W-1:0] cfg_data,
	input  logic                        advance,
	output u8mpc_pkg::ctl_t             ctl
);
	import u8mpc_pkg::*;

	logic [CFG_W-1:0]     window_size_q;
	logic [CFG_W-1:0]     channel_count_q;
	logic [BYTE_W-1:0]    clamp_low_q;
	logic [BYTE_W-1:0]    clamp_high_q;
	logic [WIN_W-1:0]     window_pos_q;
	logic [GRP_W-1:0]     group_pos_q;

	logic [CFG_W-1:0]     ws_eff;
	logic [CFG_W-1:0]     ch_eff;
	logic [CFG_W:0]       ch_round;
	logic [GRP_CNT_W-1:0] groups;
	logic [WIN_W-1:0]     w_cur;
	logic [GRP_W-1:0]     g_cur;
	logic                 emit;
	logic                 last_group;
	logic [WIN_W-1:0]     w_next;
	logic [GRP_W-1:0]     g_next;
	logic                 cfg_hit;

	always_comb begin
		if (window_size_q == '0) begin
			ws_eff = CFG_W'(1);
		end else if (window_size_q > CFG_W'(MAX_WINDOW)) begin
			ws_eff = CFG_W'(MAX_WINDOW);
		end else begin
			ws_eff = window_size_q;
		end
		if (channel_count_q == '0) begin
			ch_eff = CFG_W'(1);
		end else if (channel_count_q > CFG_W'(MAX_CHANNELS)) begin
			ch_eff = CFG_W'(MAX_CHANNELS);
		end else begin
			ch_eff = channel_count_q;
		end
		ch_round   = {1'b0, ch_eff} + (CFG_W + 1)'(LANES - 1);
		groups     = GRP_CNT_W'(ch_round >> LANE_IDX_W);
		g_cur      = ({1'b0, group_pos_q} >= groups) ? '0 : group_pos_q;
		w_cur      = ({1'b0, window_pos_q} >= ws_eff) ? '0 : window_pos_q;
		emit       = {1'b0, w_cur} == (ws_eff - CFG_W'(1));
		last_group = {1'b0, g_cur} == (groups - GRP_CNT_W'(1));
		if (last_group) begin
			g_next = '0;
			w_next = emit ? '0 : w_cur + WIN_W'(1);
		end else begin
			g_next = g_cur + GRP_W'(1);
			w_next = w_cur;
		end
	end

	always_comb begin
		case (cfg_index)
			REG_WINDOW_SIZE:   cfg_hit = 1'b1;
			REG_CHANNEL_COUNT: cfg_hit = 1'b1;
			REG_CLAMP_LOW:     cfg_hit = 1'b1;
			REG_CLAMP_HIGH:    cfg_hit = 1'b1;
			default:           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= RST_WINDOW_SIZE;
			channel_count_q <= RST_CHANNEL_COUNT;
			clamp_low_q     <= RST_CLAMP_LOW;
			clamp_high_q    <= RST_CLAMP_HIGH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_SIZE:   window_size_q   <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				REG_CLAMP_LOW:     clamp_low_q     <= cfg_data[BYTE_W-1:0];
				REG_CLAMP_HIGH:    clamp_high_q    <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_pos_q <= '0;
			group_pos_q  <= '0;
		end else if (cfg_valid && cfg_hit) begin
			window_pos_q <= '0;
			group_pos_q  <= '0;
		end else if (advance) begin
			window_pos_q <= w_next;
			group_pos_q  <= g_next;
		end
	end

	always_comb begin
		ctl.group      = g_cur;
		ctl.first      = (w_cur == '0);
		ctl.emit       = emit;
		ctl.last_group = last_group;
		ctl.chan_count = ch_eff;
		ctl.clamp_low  = clamp_low_q;
		ctl.clamp_high = clamp_high_q;
	end

endmodule

>>> rtl/u8mpc_outq.sv
module u8mpc_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  u8mpc_pkg::result_t push_data,
	output logic               full,
	output logic               valid,
	input  logic               stall,
	output u8mpc_pkg::result_t data
);
	import u8mpc_pkg::*;

	result_t    entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign pop   = valid && !stall;
	assign data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("output queue count out of range");

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full output queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && pop && !push) |=> !valid)
		else $error("output valid held after last item left");

endmodule

>>> rtl/u8_max_pool_clamp.sv
// u8_max_pool_clamp: quantized u8 max pooling with output clamp.
// Source channel (src_valid / src_stall / lane_bytes): one item is eight
// channel bytes of one window element, ordered by pixel, window element,
// then channel group. Destination channel (dst_valid / dst_stall /
// pooled_bytes / group_index / last_group): one item per group on the last
// window element, clamped to [clamp_low, clamp_high], unused lanes zero.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
// is always high; index 0 window_size, 1 channel_count, 2 clamp_low,
// 3 clamp_high. A write to a listed register restarts the stream position.
// Throughput: one item per cycle while src_stall is low, set by the
// read-modify-write of the group entry in the 32 x 64 running-max
// register file. Results are registered into the output queue.
// A two-entry output queue decouples the sides; src_stall rises only while
// both entries hold results the receiver has stalled on.
// Reset: registers take their defaults (9, 16, 0, 255), position returns
// to the first group of the first window element, the queue empties.
module u8_max_pool_clamp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic [u8mpc_pkg::DATA_W-1:0]  lane_bytes,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output logic [u8mpc_pkg::DATA_W-1:0]  pooled_bytes,
	output logic [u8mpc_pkg::GRP_W-1:0]   group_index,
	output logic                          last_group,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [u8mpc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [u8mpc_pkg::CFG_W-1:0]   cfg_data
);
	import u8mpc_pkg::*;

	ctl_t              ctl;
	logic              accept;
	logic              full;
	logic [DATA_W-1:0] running_max_q [GROUP_DEPTH];
	logic [DATA_W-1:0] old_entry;
	logic [DATA_W-1:0] new_entry;
	logic [DATA_W-1:0] pooled;
	result_t           push_data;
	result_t           head;

	assign cfg_ready = 1'b1;
	assign src_stall = full;
	assign accept    = src_valid && !full;
	assign old_entry = running_max_q[ctl.group];

	u8mpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.ctl       (ctl)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		u8mpc_lane u_lane (
			.lane_id     (LANE_IDX_W'(l)),
			.ctl         (ctl),
			.old_byte    (old_entry[l*BYTE_W +: BYTE_W]),
			.new_byte    (lane_bytes[l*BYTE_W +: BYTE_W]),
			.max_byte    (new_entry[l*BYTE_W +: BYTE_W]),
			.pooled_byte (pooled[l*BYTE_W +: BYTE_W])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			running_max_q[ctl.group] <= new_entry;
		end
	end

	always_comb begin
		push_data.pooled     = pooled;
		push_data.group      = ctl.group;
		push_data.last_group = ctl.last_group;
	end

	u8mpc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && ctl.emit),
		.push_data (push_data),
		.full      (full),
		.valid     (dst_valid),
		.stall     (dst_stall),
		.data      (head)
	);

	assign pooled_bytes = head.pooled;
	assign group_index  = head.group;
	assign last_group   = head.last_group;

endmodule
